// ----- design/gmts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gmts_pkg
// Shared types and constants for the Gumbel-max token sampler: field
// widths, register map and the fixed-point natural log table.
// ----------------------------------------------------------------------------
package gmts_pkg;

  localparam int LOGIT_W = 16;
  localparam int NOISE_W = 32;
  localparam int INDEX_W = 16;
  localparam int INV_T_W = 16;
  localparam int SCORE_W = 40;
  localparam int LN_W    = 20;   // log table entries, 20 fraction bits
  localparam int LNI_W   = 26;   // (p - 24) * ln(2), signed
  localparam int PROD_W  = 33;   // logit * inv_temperature, signed

  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [INV_T_W-1:0] INV_TEMP_RESET = 16'd4096;

  // ln(2) with 20 fraction bits, as a signed operand of the exponent term.
  localparam logic signed [LNI_W-1:0] LN2_Q20 = 26'sd726817;

  // Exponent bias of the Q8.24 noise format.
  localparam logic signed [5:0] NOISE_EXP_BIAS = 6'sd24;

  // round(ln(1 + k/16) * 2^20), k = 0..16.
  localparam logic [LN_W-1:0] LN_TABLE [17] = '{
    20'd0,      20'd63570,  20'd123504, 20'd180198, 20'd233983, 20'd285143,
    20'd333923, 20'd380534, 20'd425161, 20'd467966, 20'd509092, 20'd548665,
    20'd586800, 20'd623596, 20'd659144, 20'd693527, 20'd726817
  };

  // Register index, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_GREEDY_MODE = 1'b0,
    REG_INV_TEMP    = 1'b1
  } reg_idx_t;

endpackage : gmts_pkg
`default_nettype wire

// ----- design/gumbel_max_token_sampler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gumbel_max_token_sampler_unit
// Streams logits with Exp(1) noise and emits the index of the best
// Gumbel-max score (or plain argmax in greedy mode) on the last element.
// ----------------------------------------------------------------------------
//  Channel   Ports                                   Direction  Moves
//  input     in_valid/in_ready, in_logit/noise/last  in         one element
//  result    out_valid/out_ready, out_token_index    out        winning index
//  config    psel/penable/pwrite/paddr/pwdata/...    in/out     register access
//
//  One element is taken every cycle while in_ready is high. A transaction
//  passes an input register, a coarse and a fine normalize stage, a multiply
//  stage and a score stage, and is ranked against the running best from the
//  score register; a last element's index enters the output register when it
//  retires from the score stage. Only a last element that finds the output
//  register still full stalls the chain; empty stages upstream keep filling.
//  Reset is synchronous, clears all control state and needs no sweep.
// ----------------------------------------------------------------------------
module gumbel_max_token_sampler_unit
  import gmts_pkg::*;
#(
  parameter int MAX_ELEMENTS = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic signed [LOGIT_W-1:0] in_logit,
  input  wire logic [NOISE_W-1:0]        in_noise,
  input  wire logic                      in_last,
  // result channel
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [INDEX_W-1:0]        out_token_index,
  // configuration port
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output      logic [31:0]               prdata,
  output      logic                      pready
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                greedy_mode_r;
  logic [INV_T_W-1:0]  inv_temp_r;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      greedy_mode_r <= 1'b0;
      inv_temp_r    <= INV_TEMP_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GREEDY_MODE: greedy_mode_r <= pwdata[0];
        REG_INV_TEMP:    inv_temp_r    <= pwdata[INV_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_GREEDY_MODE: prdata = {31'b0, greedy_mode_r};
      REG_INV_TEMP:    prdata = {{(32-INV_T_W){1'b0}}, inv_temp_r};
      default:         prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic done5;
  logic out_valid_r;
  logic [INDEX_W-1:0] out_index_r;

  logic signed [LOGIT_W-1:0] s1_logit_r, s2_logit_r, s3_logit_r, s4_logit_r;
  logic s1_last_r, s2_last_r, s3_last_r, s4_last_r, s5_last_r;

  // A last element retires only when the output register can take its index.
  assign done5    = v5_r && (!s5_last_r || !out_valid_r || out_ready);
  assign en5      = !v5_r || done5;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register
  // --------------------------------------------------------------------------
  logic [NOISE_W-1:0] s1_noise_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_logit_r <= in_logit;
      s1_noise_r <= in_noise;
      s1_last_r  <= in_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: clamp zero noise and do the coarse 16-bit normalize
  // --------------------------------------------------------------------------
  logic [NOISE_W-1:0] noise_clamped;
  logic [NOISE_W-1:0] s2_x_nxt, s2_x_r;
  logic               s2_phi_nxt, s2_phi_r;

  always_comb begin
    noise_clamped = (s1_noise_r == '0) ? NOISE_W'(1) : s1_noise_r;
    if (noise_clamped[31:16] == '0) begin
      s2_x_nxt   = {noise_clamped[15:0], 16'b0};
      s2_phi_nxt = 1'b0;
    end else begin
      s2_x_nxt   = noise_clamped;
      s2_phi_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_x_r     <= s2_x_nxt;
      s2_phi_r   <= s2_phi_nxt;
      s2_logit_r <= s1_logit_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: fine normalize; leading one lands on bit 31
  // --------------------------------------------------------------------------
  logic [3:0]         lead_pos;
  logic [NOISE_W-1:0] norm_x;
  logic [3:0]         s3_k_nxt, s3_k_r;
  logic [15:0]        s3_r_nxt, s3_r_r;
  logic [4:0]         s3_p_r;

  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < 16; i++) begin
      if (s2_x_r[16+i]) lead_pos = 4'(i);
    end
    norm_x   = s2_x_r << (4'd15 - lead_pos);
    s3_k_nxt = norm_x[30:27];
    s3_r_nxt = norm_x[26:11];
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_k_r     <= s3_k_nxt;
      s3_r_r     <= s3_r_nxt;
      s3_p_r     <= {s2_phi_r, lead_pos};
      s3_logit_r <= s2_logit_r;
      s3_last_r  <= s2_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: temperature product, table interpolation, exponent term
  // --------------------------------------------------------------------------
  logic [LN_W-1:0]          ln_lo, ln_hi;
  logic [15:0]              ln_diff;
  logic [31:0]              interp_full;
  logic signed [5:0]        exp_unb;
  logic signed [PROD_W-1:0] s4_prod_nxt, s4_prod_r;
  logic signed [LNI_W-1:0]  s4_lni_nxt, s4_lni_r;
  logic [LN_W-1:0]          s4_lnf_nxt, s4_lnf_r;

  always_comb begin
    ln_lo       = LN_TABLE[{1'b0, s3_k_r}];
    ln_hi       = LN_TABLE[{1'b0, s3_k_r} + 5'd1];
    ln_diff     = 16'(ln_hi - ln_lo);
    interp_full = ln_diff * s3_r_r;
    s4_lnf_nxt  = ln_lo + LN_W'(interp_full[31:16]);
    exp_unb     = $signed({1'b0, s3_p_r}) - NOISE_EXP_BIAS;
    s4_lni_nxt  = $signed({{(LNI_W-6){exp_unb[5]}}, exp_unb}) * LN2_Q20;
    s4_prod_nxt = $signed({{(PROD_W-LOGIT_W){s3_logit_r[LOGIT_W-1]}}, s3_logit_r})
                * $signed({{(PROD_W-INV_T_W){1'b0}}, inv_temp_r});
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_prod_r  <= s4_prod_nxt;
      s4_lni_r   <= s4_lni_nxt;
      s4_lnf_r   <= s4_lnf_nxt;
      s4_logit_r <= s3_logit_r;
      s4_last_r  <= s3_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: score
  // --------------------------------------------------------------------------
  score_t score_nxt, s5_score_r;

  always_comb begin
    if (greedy_mode_r) begin
      score_nxt = {{(SCORE_W-LOGIT_W){s4_logit_r[LOGIT_W-1]}}, s4_logit_r};
    end else begin
      score_nxt = {{(SCORE_W-PROD_W){s4_prod_r[PROD_W-1]}}, s4_prod_r}
                - {{(SCORE_W-LNI_W){s4_lni_r[LNI_W-1]}}, s4_lni_r}
                - {{(SCORE_W-LN_W){1'b0}}, s4_lnf_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_score_r <= score_nxt;
      s5_last_r  <= s4_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Ranking against the running best, and the output register
  // --------------------------------------------------------------------------
  score_t               best_score_r;
  logic [INDEX_W-1:0]   best_index_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W+INDEX_W-1:0] count_ext;
  logic [INDEX_W-1:0]   count_idx;
  logic                 ranked;
  logic                 wins;
  logic [INDEX_W-1:0]   win_index;

  assign count_ext = {{INDEX_W{1'b0}}, count_r};
  assign count_idx = count_ext[INDEX_W-1:0];
  assign ranked    = count_r < CNT_MAX;
  assign wins      = ranked && (s5_score_r > best_score_r);
  assign win_index = wins ? count_idx : best_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= SCORE_MIN;
      best_index_r <= '0;
      count_r      <= '0;
    end else if (done5) begin
      if (s5_last_r) begin
        best_score_r <= SCORE_MIN;
        best_index_r <= '0;
        count_r      <= '0;
      end else if (ranked) begin
        if (wins) begin
          best_score_r <= s5_score_r;
          best_index_r <= count_idx;
        end
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done5 && s5_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done5 && s5_last_r) begin
      out_index_r <= win_index;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_token_index = out_index_r;

`ifndef SYNTHESIS
  // The element count never runs past the configured vector limit.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("element count exceeded MAX_ELEMENTS");

  // Retiring a last element restarts the vector.
  a_vector_restart: assert property (@(posedge clk) disable iff (!rst_n)
    done5 && s5_last_r |=> count_r == '0 && best_index_r == '0
                           && best_score_r == SCORE_MIN)
    else $error("vector state not cleared after last element");

  // A last element blocked by a full output register stays in the score stage.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && s5_last_r && out_valid_r && !out_ready |=> v5_r && s5_last_r)
    else $error("blocked last element was lost");

  // Back-pressure reaches the input only when every pipeline stage is occupied.
  a_ready_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && v5_r)
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule : gumbel_max_token_sampler_unit
`default_nettype wire
